[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(lbl, clk, rst, a, b)
`define TCW_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants shared by the text console writer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int WIDTH_DEF  = 80;
  localparam int HEIGHT_DEF = 25;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] COLOR_RESET  = 8'd7;

  typedef enum logic [2:0] {
    FUNC_PUT_CHAR  = 3'd0,
    FUNC_BACKSPACE = 3'd1,
    FUNC_CLEAR     = 3'd2,
    FUNC_PUT_CELL  = 3'd3,
    FUNC_READ_CELL = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BS_WR,
    ST_RD_WAIT,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_PUT,
    DP_NEWLINE,
    DP_BS_RD,
    DP_BS_WR,
    DP_PUT_CELL,
    DP_RD_CELL,
    DP_CAPTURE,
    DP_CLEAR_INIT,
    DP_COPY,
    DP_DRAIN,
    DP_FILL
  } dp_op_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] col;
    logic [4:0] row;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [15:0] cell_value;
  } rsp_t;

  typedef struct packed {
    logic [2:0] func;
    logic       is_newline;
    logic       col_last;
    logic       row_last;
    logic       at_origin;
    logic       cnt_last;
  } dp_status_t;

endpackage

[hw/rtl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// cell store, cursor registers, sweep counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_datapath #(
  parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
  parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tcw_pkg::req_t      req,
  input  tcw_pkg::dp_op_t    op,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output tcw_pkg::dp_status_t status,
  output tcw_pkg::rsp_t      rsp
);
  import tcw_pkg::*;

  localparam int NCELLS = WIDTH * HEIGHT;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(WIDTH);
  localparam int RW     = $clog2(HEIGHT);

  logic [15:0]   mem [NCELLS];
  logic [15:0]   rdata;
  req_t          item;
  logic [7:0]    text_color;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [AW-1:0] row_base;
  logic [AW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [15:0]   cell_value;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] pos_addr;
  logic          in_range;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0]   wdata;
  logic          step_row;
  logic [CW-1:0] cur_col_next;
  logic [RW-1:0] cur_row_next;
  logic [AW-1:0] row_base_next;

  assign cur_addr = row_base + AW'(cur_col);
  assign pos_addr = AW'(AW'(item.row) * AW'(WIDTH)) + AW'(item.col);
  assign in_range = ({2'b00, item.col} < 9'(WIDTH)) && ({3'b000, item.row} < 8'(HEIGHT));

  assign status.func       = item.func;
  assign status.is_newline = (item.char_code == NEWLINE_CHAR);
  assign status.col_last   = (cur_col == CW'(WIDTH - 1));
  assign status.row_last   = (cur_row == RW'(HEIGHT - 1));
  assign status.at_origin  = (cur_col == '0) && (cur_row == '0);
  assign status.cnt_last   = (cnt == AW'(NCELLS - 1));

  assign rsp.cursor_index = 11'(cur_addr);
  assign rsp.cell_value   = cell_value;

  // memory port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cur_addr;
    raddr = cur_addr;
    wdata = {text_color, item.char_code};
    case (op)
      DP_PUT: begin
        we = 1'b1;
      end
      DP_BS_RD: begin
        re = 1'b1;
      end
      DP_BS_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      DP_PUT_CELL: begin
        we    = in_range;
        waddr = pos_addr;
        wdata = {item.cell_color, item.char_code};
      end
      DP_RD_CELL: begin
        re    = 1'b1;
        raddr = pos_addr;
      end
      DP_COPY: begin
        re    = 1'b1;
        raddr = cnt;
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      DP_DRAIN: begin
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      DP_FILL: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = {text_color, BLANK_CHAR};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // cursor movement
  always_comb begin
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    row_base_next = row_base;
    step_row      = 1'b0;
    case (op)
      DP_PUT: begin
        if (status.col_last) begin
          step_row = 1'b1;
        end else begin
          cur_col_next = cur_col + 1'b1;
        end
      end
      DP_NEWLINE: begin
        step_row = 1'b1;
      end
      DP_BS_RD: begin
        if (cur_col == '0) begin
          cur_col_next  = CW'(WIDTH - 1);
          cur_row_next  = cur_row - 1'b1;
          row_base_next = row_base - AW'(WIDTH);
        end else begin
          cur_col_next = cur_col - 1'b1;
        end
      end
      DP_CLEAR_INIT: begin
        cur_col_next  = '0;
        cur_row_next  = '0;
        row_base_next = '0;
      end
      default: begin
        step_row = 1'b0;
      end
    endcase
    if (step_row) begin
      cur_col_next = '0;
      if (!status.row_last) begin
        cur_row_next  = cur_row + 1'b1;
        row_base_next = row_base + AW'(WIDTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      row_base   <= '0;
      text_color <= COLOR_RESET;
    end else begin
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      row_base <= row_base_next;
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
    end
  end

  // item, sweep counter and result
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        item       <= req;
        cell_value <= '0;
      end
      DP_CAPTURE: begin
        cell_value <= in_range ? rdata : 16'h0000;
      end
      DP_PUT, DP_NEWLINE: begin
        cnt  <= AW'(WIDTH);
        pend <= 1'b0;
      end
      DP_CLEAR_INIT: begin
        cnt <= '0;
      end
      DP_COPY: begin
        cnt       <= cnt + 1'b1;
        pend      <= 1'b1;
        pend_addr <= cnt - AW'(WIDTH);
      end
      DP_DRAIN: begin
        cnt <= AW'(NCELLS - WIDTH);
      end
      DP_FILL: begin
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  `TCW_ASSERT_IMP(a_col_range, clk, rst, 1'b1, cur_col <= CW'(WIDTH - 1))
  `TCW_ASSERT_IMP(a_row_range, clk, rst, 1'b1, cur_row <= RW'(HEIGHT - 1))
  `TCW_ASSERT_IMP(a_row_base, clk, rst, 1'b1,
                  row_base == AW'(AW'(cur_row) * AW'(WIDTH)))

endmodule

[hw/rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer for item execution, scroll copy and blank fill sweeps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::dp_op_t     op,
  output logic                busy,
  output logic                done
);
  import tcw_pkg::*;

  state_t state;
  state_t state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    op         = DP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          op         = DP_LOAD;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        case (status.func)
          FUNC_PUT_CHAR: begin
            op = status.is_newline ? DP_NEWLINE : DP_PUT;
            if (status.row_last && (status.is_newline || status.col_last)) begin
              done_next  = 1'b0;
              state_next = ST_COPY;
            end
          end
          FUNC_BACKSPACE: begin
            if (!status.at_origin) begin
              op         = DP_BS_RD;
              done_next  = 1'b0;
              state_next = ST_BS_WR;
            end
          end
          FUNC_CLEAR: begin
            op         = DP_CLEAR_INIT;
            done_next  = 1'b0;
            state_next = ST_FILL;
          end
          FUNC_PUT_CELL: begin
            op = DP_PUT_CELL;
          end
          FUNC_READ_CELL: begin
            op         = DP_RD_CELL;
            done_next  = 1'b0;
            state_next = ST_RD_WAIT;
          end
          default: begin
            op = DP_NONE;
          end
        endcase
      end
      ST_BS_WR: begin
        op         = DP_BS_WR;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_WAIT: begin
        op         = DP_CAPTURE;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        op = DP_COPY;
        if (status.cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        op         = DP_DRAIN;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        op = DP_FILL;
        if (status.cnt_last) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `TCW_ASSERT_IMP(a_done_idle, clk, rst, done, state == ST_IDLE)
  `TCW_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `TCW_ASSERT_NXT(a_accept_exec, clk, rst, start && !busy, state == ST_EXEC)
  `TCW_ASSERT_NXT(a_copy_drain, clk, rst, state == ST_COPY && status.cnt_last,
                  state == ST_DRAIN)

endmodule

[hw/rtl/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text console with cell store, cursor, wrap, scroll, backspace and clear
// ----------------------------------------------------------------------------
// usage:
//   an item on req is taken at a clock edge with start high and busy low.
//   each item gives one result on rsp, marked by done for one cycle; the
//   result cannot be held off and must be taken in that cycle.
//   cfg_data (attribute byte) is written at cfg_valid, cfg_ready is always
//   high; write it only while no item is in flight.
// steps, from accept to done:
//   put char, put cell, backspace at origin, unused codes: the execute state
//   backspace and read cell: one registered store read, then write or capture
//   put char that scrolls: copy sweep, drain, blank fill of the last row; the
//   copy moves one cell per cycle through the single write port of the store
//   clear: a blank fill of the whole store, one blank cell written per cycle
//   a new item may be accepted in the cycle that done is high.
// reset clears the cursor, sets the attribute to 7 and returns to idle;
// the store holds no reset value and is cleared by a clear item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module text_console_writer_unit #(
  parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
  parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tcw_pkg::req_t req,
  output logic          done,
  output tcw_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data
);
  import tcw_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy),
    .done   (done)
  );

  tcw_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .op        (op),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .rsp       (rsp)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the text console writer against a shadow console: a copy of the
// cell store, the cursor and the attribute byte updated for each accepted
// item. each result is compared field by field with the oldest prediction.
// directed items cover clear, backspace at the origin and across rows,
// field extremes, out-of-range positions, spare codes and row wrap; random
// traffic then drives typing, newlines, scrolls and cell access under
// several attribute settings with random start gaps.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int COLS = WIDTH_DEF;
  localparam int ROWS = HEIGHT_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam int SETTLE_CYCLES = CELLS + COLS + 8;
  localparam int STALL_LIMIT = 10 * (CELLS + COLS + 2);
  localparam int CHUNK_ITEMS = 60;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [7:0] BYTE_MIN = 8'h00;
  localparam logic [7:0] BYTE_MAX = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  logic [15:0] shadow_screen [CELLS];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;
  logic [7:0] attr = COLOR_RESET;
  rsp_t cursor_cell_q [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int wrap_count = 0;
  int spare_count = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b0;
  int gap_pct = 0;
  bit typing = 1'b0;

  text_console_writer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow console
  function automatic logic [15:0] blank_cell();
    return {attr, BLANK_CHAR};
  endfunction

  function automatic void advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = blank_cell();
      cur_row = ROWS - 1;
      scroll_count++;
    end
  endfunction

  function automatic rsp_t apply_console_access(input req_t r);
    rsp_t res;
    int unsigned pos;
    bit hit;
    res = '0;
    hit = (r.col < COLS) && (r.row < ROWS);
    case (r.func)
      FUNC_PUT_CHAR: begin
        if (r.char_code == NEWLINE_CHAR) begin
          advance_row();
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {attr, r.char_code};
          cur_col++;
          if (cur_col >= COLS) begin
            wrap_count++;
            advance_row();
          end
        end
      end
      FUNC_BACKSPACE: begin
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end else begin
            cur_col--;
          end
          pos = cur_row * COLS + cur_col;
          if (pos + 1 < CELLS) shadow_screen[pos] = shadow_screen[pos + 1];
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
        clear_count++;
      end
      FUNC_PUT_CELL: begin
        if (hit) shadow_screen[r.row * COLS + r.col] = {r.cell_color, r.char_code};
      end
      FUNC_READ_CELL: begin
        if (hit) res.cell_value = shadow_screen[r.row * COLS + r.col];
      end
      default: begin
        spare_count++;
      end
    endcase
    res.cursor_index = 11'(cur_row * COLS + cur_col);
    return res;
  endfunction

  function automatic req_t make_req(input logic [2:0] func, input logic [7:0] ch,
                                    input logic [7:0] color, input logic [6:0] col,
                                    input logic [4:0] row);
    req_t r;
    r.func = func;
    r.char_code = ch;
    r.cell_color = color;
    r.col = col;
    r.row = row;
    return r;
  endfunction

  // item send and attribute write
  task automatic send_access(input req_t r);
    if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    cursor_cell_q.push_back(apply_console_access(r));
    items_sent++;
  endtask

  task automatic write_text_color(input logic [7:0] value);
    start <= 1'b0;
    while (cursor_cell_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr = value;
  endtask

  // result check
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      results_seen++;
      if (cursor_cell_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: cursor_index %0d cell_value %h",
                 $time, rsp.cursor_index, rsp.cell_value);
      end else begin
        want = cursor_cell_q.pop_front();
        if (rsp.cursor_index !== want.cursor_index) begin
          errors++;
          $display("%0t cursor_index mismatch: expected %0d actual %0d",
                   $time, want.cursor_index, rsp.cursor_index);
        end
        if (rsp.cell_value !== want.cell_value) begin
          errors++;
          $display("%0t cell_value mismatch: expected %h actual %h",
                   $time, want.cell_value, rsp.cell_value);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // directed tests
  task automatic test_clear_and_origin();
    send_access(make_req(FUNC_CLEAR, BYTE_MIN, BYTE_MIN, 7'd0, 5'd0));
    send_access(make_req(FUNC_BACKSPACE, BYTE_MAX, BYTE_MAX, 7'd0, 5'd0));
  endtask

  task automatic test_put_char_edges();
    send_access(make_req(FUNC_PUT_CHAR, BYTE_MIN, BYTE_MIN, 7'd0, 5'd0));
    send_access(make_req(FUNC_PUT_CHAR, BYTE_MAX, BYTE_MAX, 7'd0, 5'd0));
    send_access(make_req(FUNC_PUT_CHAR, NEWLINE_CHAR, BYTE_MIN, 7'd0, 5'd0));
    // backspace from column 0 crosses to the end of the row above
    send_access(make_req(FUNC_BACKSPACE, BYTE_MIN, BYTE_MIN, 7'd0, 5'd0));
  endtask

  task automatic test_cell_access();
    send_access(make_req(FUNC_PUT_CELL, BYTE_MAX, BYTE_MAX, 7'(COLS - 1), 5'(ROWS - 1)));
    send_access(make_req(FUNC_PUT_CELL, BYTE_MIN, BYTE_MIN, 7'd0, 5'd0));
    send_access(make_req(FUNC_PUT_CELL, 8'h55, 8'hAA, 7'(COLS), 5'd0));
    send_access(make_req(FUNC_PUT_CELL, 8'hAA, 8'h55, 7'd0, 5'(ROWS)));
    send_access(make_req(FUNC_PUT_CELL, BYTE_MAX, BYTE_MAX, 7'h7F, 5'h1F));
    send_access(make_req(FUNC_READ_CELL, BYTE_MIN, BYTE_MIN, 7'(COLS - 1), 5'(ROWS - 1)));
    send_access(make_req(FUNC_READ_CELL, BYTE_MAX, BYTE_MAX, 7'd0, 5'd0));
    send_access(make_req(FUNC_READ_CELL, BYTE_MIN, BYTE_MIN, 7'h7F, 5'h1F));
    send_access(make_req(FUNC_READ_CELL, BYTE_MIN, BYTE_MIN, 7'd0, 5'(ROWS)));
  endtask

  task automatic test_spare_codes();
    for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++)
      send_access(make_req(3'(f), BYTE_MAX, BYTE_MAX, 7'd1, 5'd1));
  endtask

  task automatic test_row_wrap();
    // cursor sits on the last column, so this char wraps to the next row
    send_access(make_req(FUNC_PUT_CHAR, 8'h41, BYTE_MIN, 7'd0, 5'd0));
    send_access(make_req(FUNC_READ_CELL, BYTE_MIN, BYTE_MIN, 7'(COLS - 1), 5'd0));
  endtask

  // random traffic
  task automatic random_access();
    req_t r;
    int pick;
    r.char_code = 8'($urandom_range(0, 255));
    r.cell_color = 8'($urandom_range(0, 255));
    r.col = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, COLS - 1));
    r.row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, ROWS - 1));
    pick = $urandom_range(0, 199);
    if (typing && $urandom_range(0, 4) != 0) begin
      r.func = FUNC_PUT_CHAR;
      if (r.char_code == NEWLINE_CHAR && $urandom_range(0, 3) != 0) r.char_code = 8'h2E;
    end else if (pick < 100) begin
      r.func = FUNC_PUT_CHAR;
      if ($urandom_range(0, 6) == 0) r.char_code = NEWLINE_CHAR;
    end else if (pick < 125) begin
      r.func = FUNC_BACKSPACE;
    end else if (pick < 155) begin
      r.func = FUNC_PUT_CELL;
    end else if (pick < 190) begin
      r.func = FUNC_READ_CELL;
    end else if (pick < 199) begin
      r.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    end else begin
      r.func = FUNC_CLEAR;
    end
    // scrolls are slow, so only some of them are let through
    if (r.func == FUNC_PUT_CHAR && cur_row == ROWS - 1 &&
        (r.char_code == NEWLINE_CHAR || cur_col == COLS - 1) &&
        $urandom_range(0, 2) != 0) r.func = FUNC_READ_CELL;
    send_access(r);
  endtask

  task automatic test_random_traffic(input int count, input bit with_gaps);
    for (int n = 0; n < count; n++) begin
      if (n % CHUNK_ITEMS == 0) begin
        gaps_on = with_gaps;
        gap_pct = 25 * $urandom_range(0, 2);
        typing = $urandom_range(0, 1);
      end
      random_access();
    end
    gaps_on = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_text_color(BYTE_MAX);
    test_clear_and_origin();
    test_put_char_edges();
    test_cell_access();
    test_spare_codes();
    test_row_wrap();

    write_text_color(BYTE_MIN);
    test_random_traffic(500, 1'b1);
    write_text_color(8'($urandom_range(0, 255)));
    test_random_traffic(500, 1'b1);
    write_text_color(8'($urandom_range(0, 255)));
    test_random_traffic(500, 1'b1);
    write_text_color(8'h5A);
    test_random_traffic(400, 1'b0);

    start <= 1'b0;
    while (cursor_cell_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d results, %0d clears, %0d scrolls, %0d row wraps",
             items_sent, results_seen, clear_count, scroll_count, wrap_count);
    $display("plus %0d spare codes, under five attribute settings; %0d errors",
             spare_count, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
